// File: sv/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define CHK_ASSERT(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("ladder port check failed");

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, ck, prop) \
  label: assert property (@(posedge ck) prop) \
    else $error("ladder port check failed");

`endif

// File: sv/slp_pkg.sv
// Package: step codes, register indexes, reset values and the command struct.
`timescale 1ns / 1ps
`default_nettype none
package slp_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 19;
  localparam int KW = 3;
  localparam int OPW = 5;

  localparam logic [CFG_IW-1:0] REG_CUTOFF   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FEEDBACK = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WET_MIX  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ENABLE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CLIP     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SOFTNESS = 3'd5;
  localparam logic [CFG_IW-1:0] REG_GAIN     = 3'd6;

  localparam logic [16:0] RST_CUTOFF   = 17'd17146;
  localparam logic [18:0] RST_FEEDBACK = 19'd0;
  localparam logic [16:0] RST_WET_MIX  = 17'd0;
  localparam logic        RST_ENABLE   = 1'b1;
  localparam logic [18:0] RST_CLIP     = 19'd131072;
  localparam logic [17:0] RST_SOFTNESS = 18'd32768;
  localparam logic [16:0] RST_GAIN     = 17'd4064;

  localparam logic [16:0] CUTOFF_MAX = 17'd124518;
  localparam logic [16:0] UNITY_Q16  = 17'd65536;

  // controller states, also the datapath step codes
  localparam logic [OPW-1:0] ST_IDLE     = 5'd0;
  localparam logic [OPW-1:0] ST_SC_MUL   = 5'd1;
  localparam logic [OPW-1:0] ST_SC_UPD   = 5'd2;
  localparam logic [OPW-1:0] ST_SF_MUL   = 5'd3;
  localparam logic [OPW-1:0] ST_SF_UPD   = 5'd4;
  localparam logic [OPW-1:0] ST_FB_MUL   = 5'd5;
  localparam logic [OPW-1:0] ST_FB_CLIP  = 5'd6;
  localparam logic [OPW-1:0] ST_DEN_MUL  = 5'd7;
  localparam logic [OPW-1:0] ST_DEN_UPD  = 5'd8;
  localparam logic [OPW-1:0] ST_DIV      = 5'd9;
  localparam logic [OPW-1:0] ST_DRIVE    = 5'd10;
  localparam logic [OPW-1:0] ST_POLE_MUL = 5'd11;
  localparam logic [OPW-1:0] ST_POLE_UPD = 5'd12;
  localparam logic [OPW-1:0] ST_MIX_A    = 5'd13;
  localparam logic [OPW-1:0] ST_MIX_B    = 5'd14;
  localparam logic [OPW-1:0] ST_MIX_W    = 5'd15;
  localparam logic [OPW-1:0] ST_EMIT     = 5'd16;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic           ch;
    logic [KW-1:0]  k;
    logic           load;
    logic           emit;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/slp_ctrl.sv
// Controller: sequences the per-item steps and owns the stream handshakes.
`timescale 1ns / 1ps
`default_nettype none
module slp_ctrl #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int POLE_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        block_start,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output slp_pkg::cmd_t    cmd
);

  localparam int QB = SAMPLE_WIDTH - 2;
  localparam int CW = $clog2(QB);

  logic [slp_pkg::OPW-1:0] state, state_next;
  logic                    ch, ch_next;
  logic [slp_pkg::KW-1:0]  k, k_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic                    out_valid, out_valid_next;
  logic                    load, emit;

  assign load = (state == slp_pkg::ST_IDLE) && s_tvalid;
  assign emit = (state == slp_pkg::ST_EMIT) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    ch_next = ch;
    k_next = k;
    cnt_next = cnt;
    unique case (state)
      slp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = block_start ? slp_pkg::ST_SC_MUL : slp_pkg::ST_FB_MUL;
          ch_next = 1'b0;
        end
      end
      slp_pkg::ST_SC_MUL:  state_next = slp_pkg::ST_SC_UPD;
      slp_pkg::ST_SC_UPD:  state_next = slp_pkg::ST_SF_MUL;
      slp_pkg::ST_SF_MUL:  state_next = slp_pkg::ST_SF_UPD;
      slp_pkg::ST_SF_UPD:  state_next = slp_pkg::ST_FB_MUL;
      slp_pkg::ST_FB_MUL:  state_next = slp_pkg::ST_FB_CLIP;
      slp_pkg::ST_FB_CLIP: state_next = slp_pkg::ST_DEN_MUL;
      slp_pkg::ST_DEN_MUL: state_next = slp_pkg::ST_DEN_UPD;
      slp_pkg::ST_DEN_UPD: begin
        state_next = slp_pkg::ST_DIV;
        cnt_next = '0;
      end
      slp_pkg::ST_DIV: begin
        if (cnt == CW'(QB - 1)) begin
          state_next = slp_pkg::ST_DRIVE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      slp_pkg::ST_DRIVE: begin
        state_next = slp_pkg::ST_POLE_MUL;
        k_next = '0;
      end
      slp_pkg::ST_POLE_MUL: state_next = slp_pkg::ST_POLE_UPD;
      slp_pkg::ST_POLE_UPD: begin
        if (k == slp_pkg::KW'(POLE_COUNT - 1)) begin
          state_next = slp_pkg::ST_MIX_A;
        end else begin
          k_next = k + 1'b1;
          state_next = slp_pkg::ST_POLE_MUL;
        end
      end
      slp_pkg::ST_MIX_A: state_next = slp_pkg::ST_MIX_B;
      slp_pkg::ST_MIX_B: state_next = slp_pkg::ST_MIX_W;
      slp_pkg::ST_MIX_W: begin
        if (!ch) begin
          ch_next = 1'b1;
          state_next = slp_pkg::ST_FB_MUL;
        end else begin
          state_next = slp_pkg::ST_EMIT;
        end
      end
      slp_pkg::ST_EMIT: begin
        if (emit) begin
          state_next = slp_pkg::ST_IDLE;
        end
      end
      default: state_next = slp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slp_pkg::ST_IDLE;
      ch <= 1'b0;
      k <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch <= ch_next;
      k <= k_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == slp_pkg::ST_IDLE);
  assign m_tvalid = out_valid;

  assign cmd.op = state;
  assign cmd.ch = ch;
  assign cmd.k = k;
  assign cmd.load = load;
  assign cmd.emit = emit;

endmodule
`default_nettype wire

// File: sv/slp_dp.sv
// Datapath: registers, shared multiplier, radix-2 divider and pole storage.
`timescale 1ns / 1ps
`default_nettype none
module slp_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int POLE_COUNT = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire slp_pkg::cmd_t                   cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  left_sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  right_sample,
  input  wire logic                            cfg_valid,
  input  wire logic [slp_pkg::CFG_IW-1:0]      cfg_index,
  input  wire logic [slp_pkg::CFG_DW-1:0]      cfg_data,
  output logic signed [SAMPLE_WIDTH-1:0]       left_result,
  output logic signed [SAMPLE_WIDTH-1:0]       right_result
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = SW - 5;
  localparam int MA = SW + 2;
  localparam int MB = 20;
  localparam int PW = MA + MB;
  localparam int QB = SW - 2;
  localparam int DW = 22;
  localparam int NW = SW + 15;
  localparam int NP = 2 * POLE_COUNT;
  localparam int AW = $clog2(NP);
  localparam logic signed [MA-1:0] STG = MA'(10) <<< F;
  localparam logic signed [PW:0] SMAX = (PW+1)'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [PW:0] SMIN = -SMAX - 1;

  // configuration
  logic [16:0] reg_cut, reg_mix, reg_gain;
  logic [18:0] reg_fb, reg_clip;
  logic [17:0] reg_soft;
  logic        reg_en;
  logic        clear_all;

  assign clear_all = cfg_valid && (cfg_index == slp_pkg::REG_ENABLE) && !reg_en && cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_cut <= slp_pkg::RST_CUTOFF;
      reg_fb <= slp_pkg::RST_FEEDBACK;
      reg_mix <= slp_pkg::RST_WET_MIX;
      reg_en <= slp_pkg::RST_ENABLE;
      reg_clip <= slp_pkg::RST_CLIP;
      reg_soft <= slp_pkg::RST_SOFTNESS;
      reg_gain <= slp_pkg::RST_GAIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slp_pkg::REG_CUTOFF:   reg_cut <= cfg_data[16:0];
        slp_pkg::REG_FEEDBACK: reg_fb <= cfg_data;
        slp_pkg::REG_WET_MIX:  reg_mix <= cfg_data[16:0];
        slp_pkg::REG_ENABLE:   reg_en <= cfg_data[0];
        slp_pkg::REG_CLIP:     reg_clip <= cfg_data;
        slp_pkg::REG_SOFTNESS: reg_soft <= cfg_data[17:0];
        slp_pkg::REG_GAIN:     reg_gain <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [16:0] cut_t, mixc, gainc;
  logic [17:0] mix_inv;
  logic        bypass;
  logic [18+F:0] clip_sh;
  logic [SW-3:0] thr;

  assign cut_t = (reg_cut > slp_pkg::CUTOFF_MAX) ? slp_pkg::CUTOFF_MAX : reg_cut;
  assign mixc = (reg_mix > slp_pkg::UNITY_Q16) ? slp_pkg::UNITY_Q16 : reg_mix;
  assign gainc = (reg_gain > slp_pkg::UNITY_Q16) ? slp_pkg::UNITY_Q16 : reg_gain;
  assign mix_inv = {1'b0, slp_pkg::UNITY_Q16} - {1'b0, mixc};
  assign bypass = !reg_en || (mixc == '0);
  assign clip_sh = {reg_clip, {F{1'b0}}};
  assign thr = (SW-2)'(clip_sh >> 16);

  // item and working registers
  logic signed [SW-1:0] in_l, in_r, res_l, res_r, in_ch;
  logic [17:0] sc;
  logic [18:0] sf;
  logic [SW-3:0] mag;
  logic          neg;
  logic [DW-1:0] den, rem;
  logic [QB-1:0] qsh;
  logic signed [SW:0] drive;
  logic signed [PW:0] acc;
  logic signed [PW-1:0] prod;

  assign in_ch = cmd.ch ? in_r : in_l;

  // pole storage, one read address per cycle
  logic signed [SW-1:0] pole [NP];
  logic [AW-1:0] base, koff, addr;
  logic          use_last;
  logic signed [SW-1:0] pole_rd;

  assign use_last = (cmd.op == slp_pkg::ST_FB_MUL) || (cmd.op == slp_pkg::ST_MIX_B);
  assign base = cmd.ch ? AW'(POLE_COUNT) : '0;
  assign koff = use_last ? AW'(POLE_COUNT - 1) : AW'(cmd.k);
  assign addr = base + koff;
  assign pole_rd = pole[addr];

  // shared multiplier
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [18:0] dc;
  logic signed [19:0] dfb;

  assign dc = signed'({2'b00, cut_t}) - signed'({1'b0, sc});
  assign dfb = signed'({1'b0, reg_fb}) - signed'({1'b0, sf});

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      slp_pkg::ST_SC_MUL: begin
        ma = MA'(signed'({1'b0, gainc}));
        mb = MB'(dc);
      end
      slp_pkg::ST_SF_MUL: begin
        ma = MA'(signed'({1'b0, gainc}));
        mb = dfb;
      end
      slp_pkg::ST_FB_MUL: begin
        ma = MA'(pole_rd);
        mb = MB'(signed'({1'b0, sf}));
      end
      slp_pkg::ST_DEN_MUL: begin
        ma = MA'(signed'({1'b0, mag}));
        mb = MB'(signed'({1'b0, reg_soft}));
      end
      slp_pkg::ST_POLE_MUL: begin
        ma = MA'(drive) - MA'(pole_rd);
        mb = MB'(signed'({1'b0, sc}));
      end
      slp_pkg::ST_MIX_A: begin
        ma = MA'(in_ch);
        mb = MB'(signed'({1'b0, mix_inv}));
      end
      slp_pkg::ST_MIX_B: begin
        ma = MA'(pole_rd);
        mb = MB'(signed'({1'b0, mixc}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(ma * mb);
  end

  // rounding, clipping, divider and stage arithmetic
  logic signed [PW-1:0] r16, r17, rf, thr_s;
  logic [DW-1:0] den_c;
  logic [NW-1:0] num_c;
  logic [DW:0] trial;
  logic        qbit;
  logic signed [SW-2:0] qpos;
  logic signed [MA-1:0] s_new, s_clamp;
  logic signed [PW:0] sum_r;
  logic signed [SW-1:0] mixed;

  assign r16 = (prod + PW'(32768)) >>> 16;
  assign r17 = (prod + PW'(65536)) >>> 17;
  assign rf = (prod + (PW'(1) <<< (F - 1))) >>> F;
  assign thr_s = PW'(signed'({1'b0, thr}));
  assign den_c = DW'(rf + PW'(65536));
  assign num_c = NW'({mag, 16'b0}) + NW'(den_c >> 1);
  assign trial = {rem, qsh[QB-1]};
  assign qbit = (trial >= {1'b0, den});
  assign qpos = signed'({1'b0, qsh});
  assign s_new = MA'(pole_rd) + MA'(r17);
  assign s_clamp = (s_new > STG) ? STG : ((s_new < -STG) ? -STG : s_new);
  assign sum_r = (acc + (PW+1)'(prod) + (PW+1)'(32768)) >>> 16;
  assign mixed = (sum_r > SMAX) ? SW'(SMAX) : ((sum_r < SMIN) ? SW'(SMIN) : SW'(sum_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= 18'(slp_pkg::RST_CUTOFF);
      sf <= slp_pkg::RST_FEEDBACK;
    end else begin
      if (cmd.op == slp_pkg::ST_SC_UPD) begin
        sc <= 18'(PW'(signed'({1'b0, sc})) + r16);
      end
      if (cmd.op == slp_pkg::ST_SF_UPD) begin
        sf <= 19'(PW'(signed'({1'b0, sf})) + r16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      for (int i = 0; i < NP; i++) begin
        pole[i] <= '0;
      end
    end else if (cmd.op == slp_pkg::ST_POLE_UPD) begin
      pole[addr] <= SW'(s_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_l <= left_sample;
      in_r <= right_sample;
    end
    if (cmd.emit) begin
      left_result <= res_l;
      right_result <= res_r;
    end
    unique case (cmd.op)
      slp_pkg::ST_FB_CLIP: begin
        if (r16 > thr_s) begin
          mag <= thr;
          neg <= 1'b0;
        end else if (r16 < -thr_s) begin
          mag <= thr;
          neg <= 1'b1;
        end else begin
          mag <= (SW-2)'((r16 < 0) ? -r16 : r16);
          neg <= (r16 < 0);
        end
      end
      slp_pkg::ST_DEN_UPD: begin
        den <= den_c;
        rem <= DW'(num_c >> QB);
        qsh <= num_c[QB-1:0];
      end
      slp_pkg::ST_DIV: begin
        rem <= qbit ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        qsh <= {qsh[QB-2:0], qbit};
      end
      slp_pkg::ST_DRIVE: begin
        drive <= neg ? (SW+1)'(in_ch) + (SW+1)'(qpos) : (SW+1)'(in_ch) - (SW+1)'(qpos);
      end
      slp_pkg::ST_POLE_UPD: begin
        drive <= (SW+1)'(s_clamp);
      end
      slp_pkg::ST_MIX_B: begin
        acc <= (PW+1)'(prod);
      end
      slp_pkg::ST_MIX_W: begin
        if (cmd.ch) begin
          res_r <= bypass ? in_ch : mixed;
        end else begin
          res_l <= bypass ? in_ch : mixed;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/stereo_ladder_lowpass.sv
// Top level: stereo four-pole ladder low-pass with coefficient smoothing.
// Input channel s_*: one item is a left/right sample pair, tuser flags the
// first pair of a processing block. Output channel m_*: the mixed pair.
// Configuration channel cfg_*: register index and data, always ready; write
// only while the block is idle.
// The block works on one item at a time. It is paced by the shared multiplier
// and the one-bit-per-cycle soft-limit divider (SAMPLE_WIDTH - 2 quotient bits);
// the coefficients are smoothed only at a block start, then each channel in turn
// runs the divider and the POLE_COUNT pole updates.
// s_tready is high while idle, so a new item may be taken while the last
// result still waits in the output register; if m_tready stays low, the next
// result holds in the datapath until the output register frees.
// Reset (rst, synchronous) loads register defaults, clears the poles, returns
// the smoothed coefficients to their defaults, and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module stereo_ladder_lowpass #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int POLE_COUNT = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // left_sample, right_sample
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  // block_start
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // left_result, right_result
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [slp_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [slp_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int TDW = ((2*SAMPLE_WIDTH+7)/8)*8;

  slp_pkg::cmd_t cmd;
  logic signed [SAMPLE_WIDTH-1:0] left_result, right_result;

  assign cfg_ready = 1'b1;

  slp_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .POLE_COUNT(POLE_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .block_start(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd(cmd)
  );

  slp_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .POLE_COUNT(POLE_COUNT)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .left_sample(s_tdata[SAMPLE_WIDTH-1:0]),
    .right_sample(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .left_result(left_result),
    .right_result(right_result)
  );

  assign m_tdata = TDW'({right_result, left_result});

endmodule
`default_nettype wire

// File: sv/slp_chk.sv
// Port checker for the ladder low-pass, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module slp_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready
);

  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)
  `CHK_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `CHK_ASSERT(a_no_quick_result, clk, rst, s_tvalid && s_tready |=> !m_tvalid || $past(m_tvalid))

endmodule

bind stereo_ladder_lowpass slp_chk u_slp_chk (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready)
);
`default_nettype wire
